@@ rtl/core/lbachs_pkg.sv @@
// Shared types and constants for the LBA to CHS partition encoder.
// Used by the lane, the top level and the checker.
`default_nettype none

package lbachs_pkg;

  localparam int LBA_W   = 32;
  localparam int PC_W    = 14;
  localparam int SPT_W   = 6;
  localparam int HEAD_W  = 8;
  localparam int CYL_W   = 11;
  localparam int SHIFT_W = 5;
  localparam int OFF_W   = 64;
  localparam int DATA_W  = 11;
  localparam int IDX_W   = 2;

  localparam int LANE_LAT = LBA_W + PC_W + 2;
  localparam int PIPE_LAT = LANE_LAT + 2;

  localparam logic [SPT_W-1:0]   DEF_SPT   = 6'd63;
  localparam logic [HEAD_W-1:0]  DEF_HEADS = 8'd255;
  localparam logic [CYL_W-1:0]   DEF_CYLS  = 11'd1024;
  localparam logic [SHIFT_W-1:0] DEF_SHIFT = 5'd9;

  typedef enum logic [IDX_W-1:0] {
    REG_SHIFT = 2'd0,
    REG_SPT   = 2'd1,
    REG_HEADS = 2'd2,
    REG_CYLS  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SPT_W-1:0]  spt;
    logic [HEAD_W-1:0] heads;
    logic [CYL_W-1:0]  cyls;
    logic [PC_W-1:0]   per_cyl;
  } geo_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] sec_cyl_high;
    logic [7:0] cyl_low;
  } chs_t;

endpackage

`default_nettype wire

@@ rtl/core/lbachs_div_cell.sv @@
// One restoring division cell: one quotient bit per cycle, registered.
// Parameterized by remainder and dividend widths; no package dependency.
`default_nettype none

module lbachs_div_cell #(
  parameter int REM_W = 14,
  parameter int DVD_W = 32
) (
  input  wire logic             clk,
  input  wire logic [REM_W-1:0] divisor,
  input  wire logic [REM_W-1:0] rem_in,
  input  wire logic [DVD_W-1:0] acc_in,
  output logic      [REM_W-1:0] rem_out,
  output logic      [DVD_W-1:0] acc_out
);

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_in, acc_in[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    acc_out <= {acc_in[DVD_W-2:0], ge};
  end

endmodule

`default_nettype wire

@@ rtl/core/lbachs_lane.sv @@
// One sector lane: cylinder division chain, saturation, head/sector chain, packing.
// Depends on lbachs_pkg and lbachs_div_cell.
`default_nettype none

module lbachs_lane (
  input  wire logic                        clk,
  input  wire lbachs_pkg::geo_t            geo,
  input  wire logic [lbachs_pkg::LBA_W-1:0] lba,
  output lbachs_pkg::chs_t                 chs
);

  localparam int LW = lbachs_pkg::LBA_W;
  localparam int PW = lbachs_pkg::PC_W;
  localparam int SW = lbachs_pkg::SPT_W;

  logic [PW-1:0] rem1 [0:LW];
  logic [LW-1:0] acc1 [0:LW];
  logic [SW-1:0] rem2 [0:PW];
  logic [PW-1:0] acc2 [0:PW];
  logic          sat_line [0:PW];
  logic [9:0]    cyl_line [0:PW];
  logic          sat;
  logic [lbachs_pkg::CYL_W-1:0] cyl_max;

  assign rem1[0] = '0;
  assign acc1[0] = lba;
  assign rem2[0] = '0;

  for (genvar k = 0; k < LW; k++) begin : g_cyl
    lbachs_div_cell #(.REM_W(PW), .DVD_W(LW)) u_cell (
      .clk     (clk),
      .divisor (geo.per_cyl),
      .rem_in  (rem1[k]),
      .acc_in  (acc1[k]),
      .rem_out (rem1[k+1]),
      .acc_out (acc1[k+1])
    );
  end

  always_comb begin
    sat     = acc1[LW] >= LW'(geo.cyls);
    cyl_max = geo.cyls - 11'd1;
  end

  always_ff @(posedge clk) begin
    acc2[0]     <= rem1[LW];
    sat_line[0] <= sat;
    cyl_line[0] <= sat ? cyl_max[9:0] : acc1[LW][9:0];
  end

  for (genvar j = 0; j < PW; j++) begin : g_head
    lbachs_div_cell #(.REM_W(SW), .DVD_W(PW)) u_cell (
      .clk     (clk),
      .divisor (geo.spt),
      .rem_in  (rem2[j]),
      .acc_in  (acc2[j]),
      .rem_out (rem2[j+1]),
      .acc_out (acc2[j+1])
    );

    always_ff @(posedge clk) begin
      sat_line[j+1] <= sat_line[j];
      cyl_line[j+1] <= cyl_line[j];
    end
  end

  always_ff @(posedge clk) begin
    chs.head         <= sat_line[PW] ? geo.heads - 8'd1 : acc2[PW][7:0];
    chs.sec_cyl_high <= {cyl_line[PW][9:8],
                         sat_line[PW] ? geo.spt : rem2[PW] + 6'd1};
    chs.cyl_low      <= cyl_line[PW][7:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/lba_to_chs_partition_encoder_unit.sv @@
// Top level of the LBA to CHS partition encoder: registers, sector math, two lanes.
// Depends on lbachs_pkg and lbachs_lane.
//
//   channel   handshake              payload
//   command   start && !busy         start_offset, part_length
//   result    done (one cycle)       first_*/last_* CHS bytes
//   config    cfg_valid && cfg_ready cfg_index, cfg_data
//
// One command per cycle while busy is low; each result appears on done.
// Each result passes through the chain of 32 cylinder division cells and 14 head cells.
// busy is high during reset and clears on the first clock without rst; cfg_ready is always high.
// rst clears the registers to their defaults and drops all work in flight.
// The receiver cannot stall; results are never held.
`default_nettype none

module lba_to_chs_partition_encoder_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [lbachs_pkg::OFF_W-1:0]   start_offset,
  input  wire logic [lbachs_pkg::OFF_W-1:0]   part_length,
  output logic                                done,
  output logic [7:0]                          first_head,
  output logic [7:0]                          first_sector_cyl_high,
  output logic [7:0]                          first_cyl_low,
  output logic [7:0]                          last_head,
  output logic [7:0]                          last_sector_cyl_high,
  output logic [7:0]                          last_cyl_low,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lbachs_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [lbachs_pkg::DATA_W-1:0]  cfg_data
);

  localparam int LAT = lbachs_pkg::PIPE_LAT;

  logic [lbachs_pkg::SHIFT_W-1:0] cfg_shift;
  logic [lbachs_pkg::SPT_W-1:0]   cfg_spt;
  logic [lbachs_pkg::HEAD_W-1:0]  cfg_heads;
  logic [lbachs_pkg::CYL_W-1:0]   cfg_cyls;
  lbachs_pkg::geo_t               geo;
  lbachs_pkg::geo_t               geo_next;
  logic [lbachs_pkg::OFF_W-1:0]   off_q;
  logic [lbachs_pkg::OFF_W-1:0]   len_q;
  logic [lbachs_pkg::OFF_W-1:0]   off_sh;
  logic [lbachs_pkg::OFF_W-1:0]   len_sh;
  logic [lbachs_pkg::LBA_W-1:0]   first_lba;
  logic [lbachs_pkg::LBA_W-1:0]   last_lba;
  logic [LAT-1:0]                 vld;
  lbachs_pkg::chs_t               chs_first;
  lbachs_pkg::chs_t               chs_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_shift <= lbachs_pkg::DEF_SHIFT;
      cfg_spt   <= lbachs_pkg::DEF_SPT;
      cfg_heads <= lbachs_pkg::DEF_HEADS;
      cfg_cyls  <= lbachs_pkg::DEF_CYLS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbachs_pkg::REG_SHIFT: cfg_shift <= cfg_data[lbachs_pkg::SHIFT_W-1:0];
        lbachs_pkg::REG_SPT:   cfg_spt   <= cfg_data[lbachs_pkg::SPT_W-1:0];
        lbachs_pkg::REG_HEADS: cfg_heads <= cfg_data[lbachs_pkg::HEAD_W-1:0];
        lbachs_pkg::REG_CYLS:  cfg_cyls  <= cfg_data[lbachs_pkg::CYL_W-1:0];
      endcase
    end
  end

  always_comb begin
    geo_next.spt   = (cfg_spt == '0) ? lbachs_pkg::DEF_SPT : cfg_spt;
    geo_next.heads = (cfg_heads == '0) ? lbachs_pkg::DEF_HEADS : cfg_heads;
    geo_next.cyls  = (cfg_cyls == '0 || cfg_cyls > lbachs_pkg::DEF_CYLS) ?
                     lbachs_pkg::DEF_CYLS : cfg_cyls;
    geo_next.per_cyl = lbachs_pkg::PC_W'(geo_next.spt) *
                       lbachs_pkg::PC_W'(geo_next.heads);
  end

  always_ff @(posedge clk) begin
    geo <= geo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], start && !busy};
    end
  end

  always_comb begin
    off_sh = off_q >> cfg_shift;
    len_sh = len_q >> cfg_shift;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      off_q <= start_offset;
      len_q <= part_length;
    end
    first_lba <= off_sh[lbachs_pkg::LBA_W-1:0];
    last_lba  <= len_sh[lbachs_pkg::LBA_W-1:0] + off_sh[lbachs_pkg::LBA_W-1:0] - 32'd1;
  end

  lbachs_lane u_first (
    .clk (clk),
    .geo (geo),
    .lba (first_lba),
    .chs (chs_first)
  );

  lbachs_lane u_last (
    .clk (clk),
    .geo (geo),
    .lba (last_lba),
    .chs (chs_last)
  );

  assign done                  = vld[LAT-1];
  assign first_head            = chs_first.head;
  assign first_sector_cyl_high = chs_first.sec_cyl_high;
  assign first_cyl_low         = chs_first.cyl_low;
  assign last_head             = chs_last.head;
  assign last_sector_cyl_high  = chs_last.sec_cyl_high;
  assign last_cyl_low          = chs_last.cyl_low;

endmodule

`default_nettype wire

@@ rtl/core/lbachs_check.sv @@
// Port-level checks for the LBA to CHS partition encoder, bound to the top level.
// Depends on lbachs_pkg and lba_to_chs_partition_encoder_unit.
`default_nettype none

module lbachs_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] first_sector_cyl_high,
  input wire logic [7:0] last_sector_cyl_high
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  a_busy_only_after_reset: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy outside reset recovery");

  a_done_has_command: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lbachs_pkg::PIPE_LAT))
    else $error("result beat without matching command beat");

  a_sector_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (first_sector_cyl_high[5:0] != 6'd0 && last_sector_cyl_high[5:0] != 6'd0))
    else $error("sector field is zero");

endmodule

bind lba_to_chs_partition_encoder_unit lbachs_check u_check (.*);

`default_nettype wire
